/* design/cslt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cslt_pkg
// Shared types, character codes and classifiers for the comment stripper.
// ----------------------------------------------------------------------------
package cslt_pkg;

	localparam logic [15:0] CH_SEMI   = 16'h003B;
	localparam logic [15:0] CH_DASH   = 16'h002D;
	localparam logic [15:0] CH_BSLASH = 16'h005C;
	localparam logic [15:0] CH_DQUOTE = 16'h0022;
	localparam logic [15:0] CH_SQUOTE = 16'h0027;

	localparam logic [1:0] MODE_CODE    = 2'd0;
	localparam logic [1:0] MODE_COMMENT = 2'd1;
	localparam logic [1:0] MODE_STRING  = 2'd2;

	// queue entry between front and back: one raw unit or a line end
	typedef struct packed {
		logic [15:0] unit;
		logic        eol;
	} cslt_beat_t;

	function automatic logic is_space(input logic [15:0] c);
		return (c == 16'h0020) || (c >= 16'h0009 && c <= 16'h000D);
	endfunction

	function automatic logic is_quote(input logic [15:0] c);
		return (c == CH_DQUOTE) || (c == CH_SQUOTE);
	endfunction

	function automatic logic is_symbol(input logic [15:0] c);
		logic r;
		r = 1'b0;
		case (c)
			16'h24, 16'h21, 16'h2D, 16'h2B, 16'h2F, 16'h2A, 16'h3D, 16'h5C,
			16'h5B, 16'h7B, 16'h2E, 16'h3A, 16'h3F, 16'h28, 16'h7C, 16'h5E,
			16'h26, 16'h25, 16'h3C, 16'h2C, 16'h7E, 16'h40: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

/* design/comment_strip_line_terminator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comment_strip_line_terminator_core
// Strips comments from 16-bit source lines and appends a ';' terminator unless
// the line ends in a symbol.
// A line is taken one unit a beat through a four-beat queue into the line
// store. Once the line-end beat leaves the queue, ST_PRIME0 and ST_PRIME1
// prime the store read, ST_SCAN steps through the stored units (stopping
// early when a ';' ends the code), ST_DECIDE decides and, for a kept line,
// ST_EMIT_LD loads the first beat; an empty line goes straight to ST_DECIDE.
// Results then stream one a beat while out_stall is low. Nothing leaves the
// queue during scan and output, so in_stall rises once four beats wait.
module comment_strip_line_terminator_core import cslt_pkg::*; #(
	parameter int LINE_MAX = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        line_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_unit,
	output logic        empty_line,
	output logic        overflow,
	output logic        last
);
	cslt_beat_t q_in, q_out;
	logic q_full, q_ne, q_pop;

	assign q_in     = '{unit: code_unit, eol: line_end};
	assign in_stall = q_full;

	// front queue
	cslt_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_en(in_valid && !q_full), .wr_data(q_in), .full(q_full),
		.rd_en(q_pop), .rd_data(q_out), .not_empty(q_ne)
	);

	// line processor
	cslt_back #(.LINE_MAX(LINE_MAX)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_ne), .q_data(q_out), .q_pop(q_pop),
		.valid(out_valid), .stall(out_stall),
		.out_unit(out_unit), .empty_line(empty_line),
		.overflow(overflow), .last(last)
	);
endmodule

/* design/cslt_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cslt_queue
// Small fifo decoupling the input front from the line processor.
// ----------------------------------------------------------------------------
module cslt_queue import cslt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  cslt_beat_t wr_data,
	output logic       full,
	input  logic       rd_en,
	output cslt_beat_t rd_data,
	output logic       not_empty
);
	cslt_beat_t  mem_q [4];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  cnt_q;

	assign full      = (cnt_q == 3'd4);
	assign not_empty = (cnt_q != 3'd0);
	assign rd_data   = mem_q[rp_q];

	// payload storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 2'd1;
			if (rd_en) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, wr_en} - {2'b0, rd_en};
		end
	end
endmodule

/* design/cslt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cslt_back
// Line processor: stores raw units, scans at line end, streams the result.
// ----------------------------------------------------------------------------
module cslt_back import cslt_pkg::*; #(
	parameter int LINE_MAX = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cslt_beat_t  q_data,
	output logic        q_pop,
	output logic        valid,
	input  logic        stall,
	output logic [15:0] out_unit,
	output logic        empty_line,
	output logic        overflow,
	output logic        last
);
	localparam int AW = $clog2(LINE_MAX + 1);
	localparam int RW = $clog2(LINE_MAX);

	typedef enum logic [2:0] {ST_COLLECT, ST_PRIME0, ST_PRIME1, ST_SCAN, ST_DECIDE,
		ST_EMIT_LD, ST_EMIT} state_t;

	state_t        state_q;
	logic [15:0]   raw_q   [LINE_MAX];
	logic [15:0]   clean_q [LINE_MAX + 1];
	logic [AW-1:0] len_q, idx_q, ra_q, clen_q, oidx_q;
	logic [1:0]    mode_q;
	logic          esc_q, ovf_q, ov_line_q, first_semi_q;
	logic [15:0]   lastvis_q;
	logic [15:0]   cur_q, rd_q;
	logic [15:0]   cl_rd_q;

	// per unit scan decision; rd_q holds the unit after cur_q
	logic          has_next, has_two, emit_c, stop;
	logic [1:0]    mode_n;
	logic          esc_n;
	always_comb begin
		has_next = ({1'b0, idx_q} + 1'b1) < {1'b0, len_q};
		has_two  = ({1'b0, idx_q} + 2'd2) < {1'b0, len_q};
		emit_c   = 1'b0;
		stop     = 1'b0;
		mode_n   = mode_q;
		esc_n    = esc_q;
		if (esc_q) begin
			emit_c = 1'b1;
			esc_n  = 1'b0;
		end else if (mode_q == MODE_COMMENT) begin
			if (cur_q == CH_BSLASH) esc_n = 1'b1;
			else if (cur_q == CH_DASH && has_next && rd_q == CH_SEMI) mode_n = MODE_CODE;
		end else if (mode_q == MODE_STRING) begin
			if (cur_q == CH_BSLASH && has_two) esc_n = 1'b1;
			else if (is_quote(cur_q)) mode_n = MODE_CODE;
			emit_c = 1'b1;
		end else begin
			if (is_quote(cur_q)) begin
				mode_n = MODE_STRING;
				emit_c = 1'b1;
			end else if (cur_q == CH_SEMI) begin
				if (has_next && rd_q == CH_DASH) mode_n = MODE_COMMENT;
				else stop = 1'b1;
			end else begin
				emit_c = 1'b1;
			end
		end
	end

	// line survives unless it ends in a comment, is empty or is a lone ';'
	logic keep_line;
	assign keep_line = (mode_q != MODE_COMMENT) && (clen_q != '0) &&
		!(clen_q == AW'(1) && first_semi_q);

	// read addresses; the clean store read runs one unit ahead of the output
	logic          out_take;
	logic [RW-1:0] raw_ra;
	logic [AW-1:0] cl_next, cl_ra;
	assign out_take = (state_q == ST_EMIT) && !stall && !last;
	assign raw_ra   = (ra_q < AW'(LINE_MAX)) ? ra_q[RW-1:0] : '0;
	assign cl_next  = out_take ? oidx_q + AW'(1) : oidx_q;
	assign cl_ra    = (cl_next <= AW'(LINE_MAX)) ? cl_next : '0;

	assign q_pop = q_valid && (state_q == ST_COLLECT);

	// raw and clean line stores
	always_ff @(posedge clk) begin
		if (q_pop && !q_data.eol && len_q < AW'(LINE_MAX))
			raw_q[len_q[RW-1:0]] <= q_data.unit;
		rd_q    <= raw_q[raw_ra];
		cl_rd_q <= clean_q[cl_ra];
		if (state_q == ST_SCAN && emit_c) clean_q[clen_q] <= cur_q;
		if (state_q == ST_DECIDE && keep_line && !is_symbol(lastvis_q))
			clean_q[clen_q] <= CH_SEMI;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_COLLECT;
			len_q        <= '0;
			idx_q        <= '0;
			ra_q         <= '0;
			clen_q       <= '0;
			oidx_q       <= '0;
			mode_q       <= MODE_CODE;
			esc_q        <= 1'b0;
			ovf_q        <= 1'b0;
			ov_line_q    <= 1'b0;
			first_semi_q <= 1'b0;
			lastvis_q    <= '0;
			cur_q        <= '0;
			valid        <= 1'b0;
			out_unit     <= '0;
			empty_line   <= 1'b0;
			overflow     <= 1'b0;
			last         <= 1'b0;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (q_pop) begin
						if (q_data.eol) begin
							ov_line_q    <= ovf_q;
							ovf_q        <= 1'b0;
							idx_q        <= '0;
							ra_q         <= '0;
							clen_q       <= '0;
							oidx_q       <= '0;
							first_semi_q <= 1'b0;
							state_q      <= (len_q == '0) ? ST_DECIDE : ST_PRIME0;
						end else if (len_q < AW'(LINE_MAX)) begin
							len_q <= len_q + AW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				// first unit read in flight
				ST_PRIME0: begin
					ra_q    <= ra_q + AW'(1);
					state_q <= ST_PRIME1;
				end
				// first unit lands, its successor read in flight
				ST_PRIME1: begin
					cur_q   <= rd_q;
					ra_q    <= ra_q + AW'(1);
					state_q <= ST_SCAN;
				end
				// one stored unit a cycle
				ST_SCAN: begin
					if (!is_space(cur_q)) lastvis_q <= cur_q;
					mode_q <= mode_n;
					esc_q  <= esc_n;
					if (emit_c) begin
						clen_q <= clen_q + AW'(1);
						if (clen_q == '0) first_semi_q <= (cur_q == CH_SEMI);
					end
					cur_q <= rd_q;
					ra_q  <= ra_q + AW'(1);
					idx_q <= idx_q + AW'(1);
					if (stop || !has_next) state_q <= ST_DECIDE;
				end
				// empty line or terminator append; clean store read of unit 0
				ST_DECIDE: begin
					len_q <= '0;
					if (!keep_line) begin
						valid      <= 1'b1;
						out_unit   <= '0;
						empty_line <= 1'b1;
						overflow   <= ov_line_q;
						last       <= 1'b1;
						state_q    <= ST_EMIT;
					end else begin
						if (!is_symbol(lastvis_q)) clen_q <= clen_q + AW'(1);
						oidx_q  <= oidx_q + AW'(1);
						state_q <= ST_EMIT_LD;
					end
				end
				// first output beat
				ST_EMIT_LD: begin
					valid      <= 1'b1;
					out_unit   <= cl_rd_q;
					empty_line <= 1'b0;
					overflow   <= ov_line_q;
					last       <= (oidx_q == clen_q);
					state_q    <= ST_EMIT;
				end
				// stream the rest, one beat per accept
				ST_EMIT: begin
					if (!stall) begin
						if (last) begin
							valid   <= 1'b0;
							state_q <= ST_COLLECT;
						end else begin
							out_unit <= cl_rd_q;
							last     <= (oidx_q + AW'(1) == clen_q);
							oidx_q   <= oidx_q + AW'(1);
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end
endmodule

/* design/cslt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cslt_checker
// Port-level checks for the comment stripper.
// ----------------------------------------------------------------------------
module cslt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] out_unit,
	input logic        empty_line,
	input logic        last
);
	// stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_unit) && $stable(last))
		else $error("output beat changed under stall");

	// empty line is a single beat
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_line |-> last)
		else $error("empty line not marked last");

	// empty line carries zero unit
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_line |-> out_unit == 16'h0)
		else $error("empty line with data");
endmodule

bind comment_strip_line_terminator_core cslt_checker u_cslt_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.out_unit(out_unit), .empty_line(empty_line), .last(last)
);
